/* hw/rtl/rasb_pkg.sv */
// ----------------------------------------------------------------------------
// rasb_pkg
// Shared types and codes of the return address stack with backup.
// ----------------------------------------------------------------------------
package rasb_pkg;

	localparam int ADDR_W  = 64;
	localparam int IBYTE_W = 5;
	localparam int CFG_A_W = 1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [IBYTE_W-1:0] ibytes_t;
	typedef logic [CFG_A_W-1:0] cfg_addr_t;

	// request operation
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// configuration register indexes
	localparam cfg_addr_t CFG_ENABLE_BACKUP = 1'b0;
	localparam cfg_addr_t CFG_INSTR_BYTES   = 1'b1;

	localparam ibytes_t IBYTES_RESET = 5'd4;

endpackage

/* hw/rtl/rasb_if.sv */
// ----------------------------------------------------------------------------
// rasb_if
// Request, response and configuration channels of the return address stack.
// ----------------------------------------------------------------------------
interface rasb_req_if import rasb_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  opcode;
	addr_t call_address;

	modport source (output valid, output opcode, output call_address, input ready);
	modport sink   (input valid, input opcode, input call_address, output ready);
endinterface

interface rasb_rsp_if import rasb_pkg::*; ();
	logic  valid;
	logic  ready;
	addr_t return_address;

	modport source (output valid, output return_address, input ready);
	modport sink   (input valid, input return_address, output ready);
endinterface

interface rasb_cfg_if import rasb_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_addr_t addr;
	ibytes_t   data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

/* hw/rtl/rasb_ram.sv */
// ----------------------------------------------------------------------------
// rasb_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rasb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data when no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/return_address_stack_with_backup.sv */
// ----------------------------------------------------------------------------
// return_address_stack_with_backup
// Return address stack for branch prediction, with an optional backup stack.
// ----------------------------------------------------------------------------
// Calls push call_address + instruction_bytes, returns pop one predicted
// return address. Main and backup stacks each live in a RAM with a
// registered read, and one request is in work at a time. A push with the
// backup disabled is done in the idle state; a push with the backup enabled
// first reads the oldest backup entry, then spills it and writes the backup;
// a pop first reads the RAM, then gives the response and refills the backup,
// and waits there while an earlier response is still not taken. After reset
// a clearing pass zeroes both RAMs before the first request is taken;
// configuration writes are taken at any time.
module return_address_stack_with_backup import rasb_pkg::*; #(
	parameter int STACK_DEPTH  = 16,
	parameter int BACKUP_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	rasb_req_if.sink   req,
	rasb_rsp_if.source rsp,
	rasb_cfg_if.sink   cfg
);

	localparam int MAIN_AW  = $clog2(STACK_DEPTH);
	localparam int BK_AW    = (BACKUP_DEPTH > 1) ? $clog2(BACKUP_DEPTH) : 1;
	localparam int BACK_OFS = BACKUP_DEPTH % STACK_DEPTH;
	localparam int CLR_N    = (STACK_DEPTH > BACKUP_DEPTH) ? STACK_DEPTH : BACKUP_DEPTH;
	localparam int CLR_W    = $clog2(CLR_N);

	typedef logic [MAIN_AW-1:0] main_idx_t;
	typedef logic [BK_AW-1:0]   bk_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR   = 4'b0001,
		ST_IDLE    = 4'b0010,
		ST_PUSH_RD = 4'b0100,
		ST_POP_RD  = 4'b1000
	} state_t;

	function automatic main_idx_t main_inc(input main_idx_t t);
		return (t == MAIN_AW'(STACK_DEPTH - 1)) ? '0 : t + MAIN_AW'(1);
	endfunction

	function automatic main_idx_t main_dec(input main_idx_t t);
		return (t == '0) ? MAIN_AW'(STACK_DEPTH - 1) : t - MAIN_AW'(1);
	endfunction

	// position BACKUP_DEPTH entries below t, wrapped
	function automatic main_idx_t main_back(input main_idx_t t);
		return (32'(t) >= BACK_OFS) ? t - MAIN_AW'(BACK_OFS)
			: t + MAIN_AW'(STACK_DEPTH - BACK_OFS);
	endfunction

	function automatic bk_idx_t bk_inc(input bk_idx_t t);
		return (t == BK_AW'(BACKUP_DEPTH - 1)) ? '0 : t + BK_AW'(1);
	endfunction

	function automatic bk_idx_t bk_dec(input bk_idx_t t);
		return (t == '0) ? BK_AW'(BACKUP_DEPTH - 1) : t - BK_AW'(1);
	endfunction

	state_t     state_q;
	logic [CLR_W-1:0] clr_q;
	main_idx_t  main_top_q;
	bk_idx_t    bk_top_q;
	logic       en_q;
	ibytes_t    ibytes_q;
	addr_t      ret_s1;
	main_idx_t  spill_s1;
	addr_t      out_q;
	logic       out_valid_q;

	logic       m_we, m_re, b_we, b_re;
	main_idx_t  m_waddr, m_raddr;
	bk_idx_t    b_waddr, b_raddr;
	addr_t      m_wdata, b_wdata, m_rdata, b_rdata;

	logic       req_acc;
	logic       out_free;
	addr_t      ret_addr;
	main_idx_t  top_dec;
	bk_idx_t    bk_top_dec;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign ret_addr   = req.call_address + ADDR_W'(ibytes_q);
	assign top_dec    = main_dec(main_top_q);
	assign bk_top_dec = bk_dec(bk_top_q);

	assign rsp.valid          = out_valid_q;
	assign rsp.return_address = out_q;
	assign cfg.ready          = 1'b1;

	always_comb begin
		m_we    = 1'b0;
		m_waddr = main_top_q;
		m_wdata = ret_addr;
		m_re    = 1'b0;
		m_raddr = top_dec;
		b_we    = 1'b0;
		b_waddr = bk_top_q;
		b_wdata = ret_s1;
		b_re    = 1'b0;
		b_raddr = bk_top_q;
		case (state_q)
			ST_CLEAR: begin
				m_we    = 32'(clr_q) < STACK_DEPTH;
				m_waddr = clr_q[MAIN_AW-1:0];
				m_wdata = '0;
				b_we    = 32'(clr_q) < BACKUP_DEPTH;
				b_waddr = clr_q[BK_AW-1:0];
				b_wdata = '0;
			end
			ST_IDLE: begin
				if (req_acc && req.opcode == OP_PUSH) begin
					m_we = 1'b1;
					b_re = en_q;
				end else if (req_acc) begin
					m_re    = 1'b1;
					m_raddr = en_q ? main_back(top_dec) : top_dec;
					b_re    = en_q;
					b_raddr = bk_top_dec;
				end
			end
			ST_PUSH_RD: begin
				// spill the oldest backup entry; when it lands on the new
				// entry's slot the new entry wins
				m_we    = (BACK_OFS != 0);
				m_waddr = spill_s1;
				m_wdata = b_rdata;
				b_we    = 1'b1;
			end
			ST_POP_RD: begin
				b_we    = en_q && out_free;
				b_wdata = m_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			main_top_q  <= '0;
			bk_top_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_POP_RD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc && req.opcode == OP_PUSH) begin
						main_top_q <= main_inc(main_top_q);
						if (en_q) begin
							state_q <= ST_PUSH_RD;
						end
					end else if (req_acc) begin
						main_top_q <= top_dec;
						if (en_q) begin
							bk_top_q <= bk_top_dec;
						end
						state_q <= ST_POP_RD;
					end
				end
				ST_PUSH_RD: begin
					bk_top_q <= bk_inc(bk_top_q);
					state_q  <= ST_IDLE;
				end
				ST_POP_RD: begin
					// hold until the response register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q     <= 1'b0;
			ibytes_q <= IBYTES_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				CFG_ENABLE_BACKUP: en_q     <= cfg.data[0];
				CFG_INSTR_BYTES:   ibytes_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc) begin
			ret_s1   <= ret_addr;
			spill_s1 <= main_back(main_top_q);
		end
		if (state_q == ST_POP_RD && out_free) begin
			out_q <= en_q ? b_rdata : m_rdata;
		end
	end

	rasb_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (STACK_DEPTH),
		.AW    (MAIN_AW)
	) u_main_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (m_re),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	rasb_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (BACKUP_DEPTH),
		.AW    (BK_AW)
	) u_backup_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

endmodule

/* hw/rtl/rasb_checker.sv */
// ----------------------------------------------------------------------------
// rasb_checker
// Port-level checks of the return address stack, bound to the top level.
// ----------------------------------------------------------------------------
module rasb_checker import rasb_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  req_valid,
	input logic  req_ready,
	input logic  req_opcode,
	input logic  rsp_valid,
	input logic  rsp_ready,
	input addr_t rsp_return_address
);

	logic pop_req, push_req;

	assign pop_req  = req_valid && req_ready && req_opcode == OP_POP;
	assign push_req = req_valid && req_ready && req_opcode == OP_PUSH;

	// a pending response holds its data
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_return_address))
		else $error("response dropped or changed while stalled");

	// a pop blocks the next request while its read is in flight
	a_pop_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pop_req |=> !req_ready)
		else $error("request taken while a pop is in flight");

	// a push never produces a response
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		push_req && !rsp_valid |=> !rsp_valid)
		else $error("response after a push");

	// a fresh response comes from a pop that was taken earlier
	a_rsp_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(pop_req, 2))
		else $error("response without a matching pop");

endmodule

bind return_address_stack_with_backup rasb_checker u_rasb_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.req_opcode         (req.opcode),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_return_address (rsp.return_address)
);

/* bench/tb_return_address_stack_with_backup.sv */
// ----------------------------------------------------------------------------
// tb_return_address_stack_with_backup
// Self-checking bench for the return address stack with backup.
// ----------------------------------------------------------------------------
// A directed warm-up covers wrap of the return address, underflow and
// toggling of the backup stack. Random phases follow, each with its own
// register settings, and run call/return nests with random addresses. A
// shadow stack predicts every popped return address. The request and response
// sides idle at random, and one phase runs with no idling at all.
module tb_return_address_stack_with_backup;
	import rasb_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int BACKUP_DEPTH = 4;
	localparam int MAIN_W       = $clog2(STACK_DEPTH);
	localparam int BAK_W        = $clog2(BACKUP_DEPTH);
	localparam int STALL_LIMIT  = 4000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 178;

	typedef struct {
		logic  op;
		addr_t addr;
		bit    sync;
	} ras_req_t;

	logic clk;
	logic arst_n;

	rasb_req_if req ();
	rasb_rsp_if rsp ();
	rasb_cfg_if cfg ();

	return_address_stack_with_backup #(
		.STACK_DEPTH (STACK_DEPTH),
		.BACKUP_DEPTH(BACKUP_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	// shadow stacks and register copies
	addr_t             shadow_main [STACK_DEPTH];
	logic [MAIN_W-1:0] shadow_top;
	addr_t             shadow_bak [BACKUP_DEPTH];
	logic [BAK_W-1:0]  shadow_bak_top;
	logic              backup_on;
	ibytes_t           ibytes_cfg;

	ras_req_t req_backlog[$];
	addr_t    ret_expected[$];
	ras_req_t drv_next;
	addr_t    ret_want;
	int       fails;
	int       idle_pct;
	int       stall_cycles;
	int       nest;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// advance the shadow stacks by one accepted request
	task automatic track_request(input logic op, input addr_t addr);
		addr_t                   ret;
		logic [MAIN_W-1:0] spill;
		if (op == OP_PUSH) begin
			ret = addr + addr_t'(ibytes_cfg);
			if (backup_on) begin
				spill = shadow_top - MAIN_W'(BACKUP_DEPTH % STACK_DEPTH);
				shadow_main[spill] = shadow_bak[shadow_bak_top];
				shadow_bak[shadow_bak_top] = ret;
				shadow_bak_top = shadow_bak_top + 1'b1;
			end
			shadow_main[shadow_top] = ret;
			shadow_top = shadow_top + 1'b1;
		end else begin
			shadow_top = shadow_top - 1'b1;
			ret = shadow_main[shadow_top];
			if (backup_on) begin
				spill = shadow_top - MAIN_W'(BACKUP_DEPTH % STACK_DEPTH);
				shadow_bak_top = shadow_bak_top - 1'b1;
				ret = shadow_bak[shadow_bak_top];
				shadow_bak[shadow_bak_top] = shadow_main[spill];
			end
			ret_expected.push_back(ret);
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready)
				track_request(req.opcode, req.call_address);
			if (!req.valid || req.ready) begin
				// hold a sync request until every pop has been answered
				if (req_backlog.size() > 0 &&
				    !(req_backlog[0].sync && ret_expected.size() > 0) &&
				    $urandom_range(99) >= idle_pct) begin
					drv_next = req_backlog.pop_front();
					req.valid <= 1'b1;
					req.opcode <= drv_next.op;
					req.call_address <= drv_next.addr;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (ret_expected.size() == 0) begin
					if (fails < 10)
						$display("unexpected response: return_address %h", rsp.return_address);
					fails++;
				end else begin
					ret_want = ret_expected.pop_front();
					if (rsp.return_address !== ret_want) begin
						if (fails < 10)
							$display("return_address mismatch: expected %h actual %h",
								ret_want, rsp.return_address);
						fails++;
					end
				end
			end
			rsp.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog: cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
		    (cfg.valid && cfg.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic add_req(input logic op, input addr_t addr, input bit sync = 1'b0);
		ras_req_t r;
		r.op = op;
		r.addr = addr;
		r.sync = sync;
		req_backlog.push_back(r);
	endtask

	task automatic write_reg(input cfg_addr_t idx, input ibytes_t val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == CFG_ENABLE_BACKUP)
			backup_on = val[0];
		else
			ibytes_cfg = val;
		cfg.valid <= 1'b0;
	endtask

	// drain: backlog sent, every pop answered, then let a trailing push finish
	task automatic settle();
		do @(posedge clk); while (req_backlog.size() > 0 || req.valid ||
			ret_expected.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic addr_t pick_addr();
		case ($urandom_range(9))
			0: pick_addr = '1 - addr_t'($urandom_range(40));
			1: pick_addr = addr_t'($urandom_range(255));
			default: pick_addr = {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_PUSH;
		req.call_address = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = CFG_ENABLE_BACKUP;
		cfg.data = '0;
		for (int i = 0; i < STACK_DEPTH; i++)
			shadow_main[i] = '0;
		for (int i = 0; i < BACKUP_DEPTH; i++)
			shadow_bak[i] = '0;
		shadow_top = '0;
		shadow_bak_top = '0;
		backup_on = 1'b0;
		ibytes_cfg = IBYTES_RESET;
		fails = 0;
		idle_pct = 28;
		stall_cycles = 0;
		nest = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: address wrap, then underflow into a zero entry
		add_req(OP_PUSH, '0);
		add_req(OP_PUSH, '1);
		add_req(OP_POP, '0);
		add_req(OP_POP, '1);
		add_req(OP_POP, '0);
		add_req(OP_PUSH, 64'h8000_0000_0000_0000);
		add_req(OP_PUSH, 64'h7fff_ffff_ffff_ffff);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		settle();

		// backup on, zero size, underflow through the backup stack
		write_reg(CFG_INSTR_BYTES, 5'd0);
		write_reg(CFG_ENABLE_BACKUP, 5'd1);
		add_req(OP_PUSH, 64'h0000_0000_0000_1000);
		add_req(OP_PUSH, '1);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		settle();

		// backup off with an out of range size, then back on as it stood
		write_reg(CFG_ENABLE_BACKUP, 5'd0);
		write_reg(CFG_INSTR_BYTES, 5'd31);
		add_req(OP_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
		add_req(OP_PUSH, 64'h5555_5555_5555_5555);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		settle();
		write_reg(CFG_ENABLE_BACKUP, 5'd1);
		write_reg(CFG_INSTR_BYTES, 5'd16);
		add_req(OP_POP, '0);
		add_req(OP_POP, '0);
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(CFG_ENABLE_BACKUP, ibytes_t'(p % 3 != 0));
			case (p % 5)
				0: write_reg(CFG_INSTR_BYTES, 5'd1);
				1: write_reg(CFG_INSTR_BYTES, 5'd16);
				2: write_reg(CFG_INSTR_BYTES, 5'd0);
				3: write_reg(CFG_INSTR_BYTES, 5'd31);
				default: write_reg(CFG_INSTR_BYTES, ibytes_t'($urandom_range(31)));
			endcase
			idle_pct = (p == 3) ? 0 : 28;
			nest = 0;
			// call/return nests that now and then run past the stack depth
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((nest == 0 && $urandom_range(9) != 0) ||
				    (nest > 0 && nest < 3 && $urandom_range(99) < 70) ||
				    (nest >= 3 && nest <= STACK_DEPTH + 2 && $urandom_range(1) == 0)) begin
					add_req(OP_PUSH, pick_addr(), n == PHASE_ITEMS / 2);
					nest++;
				end else begin
					add_req(OP_POP, pick_addr(), n == PHASE_ITEMS / 2);
					if (nest > 0)
						nest--;
				end
			end
			settle();
		end

		if (fails == 0 && ret_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
